// ===== rtl/lsq_pkg.sv =====
// shared types, constants and helpers for the least-squares line fit unit
package lsq_pkg;

    localparam int MAX_SAMPLES = 65536;
    localparam int CNT_W       = 17;
    localparam int DIV_STEPS   = 80;
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SAMPLES);

    typedef enum logic [1:0] {
        FIT_OK         = 2'd0,
        FIT_NO_DATA    = 2'd1,
        FIT_DEGENERATE = 2'd2,
        FIT_OVERFLOW   = 2'd3
    } fit_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_DIV_B,
        ST_MUL_B,
        ST_DIV_A,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
    } in_t;

    typedef struct packed {
        logic signed [31:0] intercept;
        logic signed [31:0] slope;
        logic [16:0]        sample_count;
        fit_status_t        fit_status;
    } out_t;

    typedef struct packed {
        logic               is_finish;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } item_t;

    typedef struct packed {
        logic        start;
        logic        fb16;
        logic [63:0] mag;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quo;
    } div_rsp_t;

    // saturate a sign and magnitude pair to signed 32 bits
    function automatic logic [31:0] sat32(input logic neg, input logic [32:0] mag);
        logic [31:0] r;
        if (neg) begin
            if (mag >= 33'h0_8000_0000)
                r = 32'h8000_0000;
            else
                r = 32'(-mag[31:0]);
        end
        else begin
            if (mag >= 33'h0_7FFF_FFFF)
                r = 32'h7FFF_FFFF;
            else
                r = mag[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/lsq_front.sv =====
// front end: takes request beats, classifies them and queues them for the back end
module lsq_front
    import lsq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  in_t   req,
    output logic  item_valid,
    output item_t item,
    input  logic  item_pop
);

    item_t       q_mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    item_t       item_in;

    assign req_ready  = (count_reg != 2'd2);
    assign push       = req_valid && req_ready;
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_mem[rd_ptr_reg];

    always_comb
    begin
        item_in.is_finish = req.req_type;
        item_in.x         = req.x_sample;
        item_in.y         = req.y_sample;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= item_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (item_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(item_pop);
        end
    end

endmodule

// ===== rtl/lsq_div.sv =====
// bit-serial restoring divider with round-to-nearest and cap at 2^32
module lsq_div
    import lsq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic        rnd_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [79:0] dvd_reg;
    logic [63:0] den_reg;
    logic [63:0] rem_reg;
    logic [32:0] q_reg;
    logic        ovf_reg;
    logic [32:0] quo_reg;
    logic [64:0] trial;
    logic        fits;
    logic [63:0] rem_next;
    logic        up;
    logic [33:0] qr;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[79]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? 64'(trial - {1'b0, den_reg}) : trial[63:0];
        up       = {rem_reg, 1'b0} >= {1'b0, den_reg};
        qr       = {1'b0, q_reg} + 34'(up);
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            dvd_reg <= req.fb16 ? {req.mag, 16'b0} : {16'b0, req.mag};
            den_reg <= req.den;
            rem_reg <= 64'd0;
            q_reg   <= 33'd0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[78:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[31:0], fits};
            ovf_reg <= ovf_reg | q_reg[32];
        end
        if (rnd_reg)
        begin
            if (ovf_reg || qr > 34'h1_0000_0000)
                quo_reg <= 33'h1_0000_0000;
            else
                quo_reg <= qr[32:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= rnd_reg;
            rnd_reg  <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    rnd_reg  <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/lsq_back.sv =====
// back end: running sums, finish sequencer with shared multiplier, result register
module lsq_back
    import lsq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  item_t    item,
    output logic     item_pop,
    output div_req_t div_req,
    input  div_rsp_t div_rsp,
    output logic     res_valid,
    input  logic     res_ready,
    output out_t     res
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [CNT_W-1:0]   cnt_acc_reg;
    logic signed [31:0] sx_reg;
    logic signed [31:0] sy_reg;
    logic [46:0]        sxx_reg;
    logic signed [47:0] sxy_reg;
    logic               ovf_reg;

    logic [CNT_W-1:0]   w_n_reg;
    logic signed [31:0] w_sx_reg;
    logic signed [31:0] w_sy_reg;
    logic [46:0]        w_sxx_reg;
    logic [47:0]        w_sxy_reg;
    logic               w_ovf_reg;

    logic [3:0]         step_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        den_reg;
    logic [63:0]        num_reg;
    logic               neg_reg;
    logic [31:0]        b_reg;
    out_t               res_reg;

    logic [2:0]         mul_idx;
    logic [31:0]        ax;
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [65:0] prod_full;
    logic [63:0]        inum;
    logic [31:0]        xx;
    logic [31:0]        xy;
    logic               start_b;
    logic               start_a;

    assign ax        = w_sx_reg[31] ? 32'(-w_sx_reg) : w_sx_reg;
    assign mul_idx   = (state_reg == ST_MUL_B) ? 3'd6 : step_reg[3:1];
    assign prod_full = op_a * op_b;
    assign inum      = {{16{w_sy_reg[31]}}, w_sy_reg, 16'b0} - prod_reg;
    assign xx        = 32'(item.x * item.x);
    assign xy        = 32'(item.x * item.y);

    always_comb
    begin
        case (mul_idx)
            3'd0:
            begin
                op_a = {16'b0, w_n_reg};
                op_b = {9'b0, w_sxx_reg[23:0]};
            end
            3'd1:
            begin
                op_a = {16'b0, w_n_reg};
                op_b = {10'b0, w_sxx_reg[46:24]};
            end
            3'd2:
            begin
                op_a = {1'b0, ax};
                op_b = {1'b0, ax};
            end
            3'd3:
            begin
                op_a = {16'b0, w_n_reg};
                op_b = {9'b0, w_sxy_reg[23:0]};
            end
            3'd4:
            begin
                op_a = {16'b0, w_n_reg};
                op_b = {{9{w_sxy_reg[47]}}, w_sxy_reg[47:24]};
            end
            3'd5:
            begin
                op_a = {w_sx_reg[31], w_sx_reg};
                op_b = {w_sy_reg[31], w_sy_reg};
            end
            default:
            begin
                op_a = {b_reg[31], b_reg};
                op_b = {w_sx_reg[31], w_sx_reg};
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        item_pop   = 1'b0;
        start_b    = 1'b0;
        start_a    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    if (item.is_finish)
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (step_reg == 4'd11)
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (w_n_reg == '0 || den_reg == 64'd0)
                    state_next = ST_OUT;
                else
                begin
                    start_b    = 1'b1;
                    state_next = ST_DIV_B;
                end
            end
            ST_DIV_B:
            begin
                if (div_rsp.done)
                    state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                if (step_reg[0])
                begin
                    start_a    = 1'b1;
                    state_next = ST_DIV_A;
                end
            end
            ST_DIV_A:
            begin
                if (div_rsp.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        div_req.start = start_b || start_a;
        div_req.fb16  = start_b;
        if (start_b)
        begin
            div_req.mag = num_reg[63] ? 64'(-num_reg) : num_reg;
            div_req.den = den_reg;
        end
        else
        begin
            div_req.mag = inum[63] ? 64'(-inum) : inum;
            div_req.den = {39'b0, w_n_reg, 8'b0};
        end
    end

    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // running sums, cleared when a finish beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_acc_reg <= '0;
            sx_reg      <= '0;
            sy_reg      <= '0;
            sxx_reg     <= '0;
            sxy_reg     <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (item_pop)
        begin
            if (item.is_finish)
            begin
                cnt_acc_reg <= '0;
                sx_reg      <= '0;
                sy_reg      <= '0;
                sxx_reg     <= '0;
                sxy_reg     <= '0;
                ovf_reg     <= 1'b0;
            end
            else if (cnt_acc_reg == MAX_COUNT)
                ovf_reg <= 1'b1;
            else
            begin
                cnt_acc_reg <= cnt_acc_reg + CNT_W'(1);
                sx_reg      <= sx_reg + 32'(item.x);
                sy_reg      <= sy_reg + 32'(item.y);
                sxx_reg     <= sxx_reg + {15'b0, xx};
                sxy_reg     <= sxy_reg + {{16{xy[31]}}, xy};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= 4'd0;
        else if (state_reg == ST_MUL || state_reg == ST_MUL_B)
            step_reg <= (state_next == state_reg) ? step_reg + 4'd1 : 4'd0;
        else
            step_reg <= 4'd0;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[63:0];
        if (item_pop && item.is_finish)
        begin
            w_n_reg   <= cnt_acc_reg;
            w_sx_reg  <= sx_reg;
            w_sy_reg  <= sy_reg;
            w_sxx_reg <= sxx_reg;
            w_sxy_reg <= sxy_reg;
            w_ovf_reg <= ovf_reg;
        end
        // odd steps fold the product of the previous even step
        if (state_reg == ST_MUL && step_reg[0])
        begin
            case (step_reg[3:1])
                3'd0:    den_reg <= prod_reg;
                3'd1:    den_reg <= den_reg + {prod_reg[39:0], 24'b0};
                3'd2:    den_reg <= den_reg - prod_reg;
                3'd3:    num_reg <= prod_reg;
                3'd4:    num_reg <= num_reg + {prod_reg[39:0], 24'b0};
                default: num_reg <= num_reg - prod_reg;
            endcase
        end
        if (start_b)
            neg_reg <= num_reg[63];
        if (start_a)
            neg_reg <= inum[63];
        if (state_reg == ST_DIV_B && div_rsp.done)
            b_reg <= sat32(neg_reg, div_rsp.quo);
        if (state_reg == ST_CHK)
        begin
            res_reg.intercept    <= '0;
            res_reg.slope        <= '0;
            res_reg.sample_count <= w_n_reg;
            if (w_n_reg == '0)
                res_reg.fit_status <= FIT_NO_DATA;
            else
                res_reg.fit_status <= FIT_DEGENERATE;
        end
        if (state_reg == ST_DIV_A && div_rsp.done)
        begin
            res_reg.intercept    <= sat32(neg_reg, div_rsp.quo);
            res_reg.slope        <= b_reg;
            res_reg.sample_count <= w_n_reg;
            res_reg.fit_status   <= w_ovf_reg ? FIT_OVERFLOW : FIT_OK;
        end
    end

    a_finish_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (item_pop && item.is_finish) |=> (state_reg == ST_MUL))
        else $error("finish beat did not start the fit sequence");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_B || state_reg == ST_DIV_A))
        else $error("divider finished outside a divide state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_acc_reg <= MAX_COUNT)
        else $error("pair count beyond limit");

    a_ovf_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (cnt_acc_reg == MAX_COUNT))
        else $error("overflow flag set below limit");

endmodule

// ===== rtl/least_squares_line_fit_unit.sv =====
// top level of the least-squares line fit unit
//
//  channel | dir | handshake             | beat
//  req     | in  | req_valid / req_ready | in_t: req_type, x_sample, y_sample
//  res     | out | res_valid / res_ready | out_t: intercept, slope, sample_count, fit_status
//
// sample beats are summed at one per cycle while the back end is idle; a two-entry queue sits
// in front of the sums; a finish beat runs 12 multiply/fold steps on one shared 33x33
// multiplier, then, unless the count or denominator is zero, two passes through the bit-serial
// divider with rounding each; the queue takes up to two beats while a fit runs or a result
// waits on res_ready; reset clears all sums, the count, the overflow flag and the queue
module least_squares_line_fit_unit
    import lsq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  in_t  req,
    output logic res_valid,
    input  logic res_ready,
    output out_t res
);

    logic     item_valid;
    item_t    item;
    logic     item_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    lsq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    lsq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lsq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule
